// ===== sv/rlt_pkg.sv =====
// Shared types and status codes for the range lock table.
`timescale 1ns / 1ps
`default_nettype none
package rlt_pkg;
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_CONFLICT       = 3'd1;
    localparam logic [2:0] ST_LOCK_FULL      = 3'd2;
    localparam logic [2:0] ST_ACTIVE_FULL    = 3'd3;
    localparam logic [2:0] ST_COMMITTED_FULL = 3'd4;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    // packed from the top down, so s_lo sits in the lowest bits
    typedef struct packed {
        logic [31:0] o_hi;
        logic [31:0] o_lo;
        logic [31:0] p_hi;
        logic [31:0] p_lo;
        logic [31:0] s_hi;
        logic [31:0] s_lo;
    } t_box;
endpackage
`default_nettype wire

// ===== sv/rlt_id_cell.sv =====
// One slot of an ID set (active or committed): holds an ID, valid bit.
`timescale 1ns / 1ps
`default_nettype none
module rlt_id_cell (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_wr,
    input  wire  [31:0] i_wr_id,
    input  wire         i_clr_eq,
    input  wire         i_clr_le,
    input  wire  [31:0] i_key,
    output logic        o_valid,
    output logic [31:0] o_id,
    output logic        o_hit
);
    logic        r_valid;
    logic [31:0] r_id;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end else if ((i_clr_eq && r_id == i_key) || (i_clr_le && r_id <= i_key)) begin
            r_valid <= 1'b0;
        end
        if (i_wr) r_id <= i_wr_id;
    end
    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_hit   = r_valid && (r_id == i_key);
endmodule
`default_nettype wire

// ===== sv/rlt_lock_cell.sv =====
// One lock slot: box, owner, mode; evaluates overlap with the request.
`timescale 1ns / 1ps
`default_nettype none
module rlt_lock_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr,
    input  wire               i_purge,
    input  wire  [31:0]       i_txn,
    input  rlt_pkg::t_box     i_box,
    input  wire               i_excl,
    output logic              o_valid,
    output logic [31:0]       o_owner,
    output logic              o_candidate
);
    logic          r_valid;
    logic [31:0]   r_owner;
    logic          r_excl;
    rlt_pkg::t_box r_box;
    logic          w_ovl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end else if (i_purge && r_owner <= i_txn) begin
            r_valid <= 1'b0;
        end
        if (i_wr) begin
            r_owner <= i_txn;
            r_excl  <= i_excl;
            r_box   <= i_box;
        end
    end
    assign w_ovl = r_box.s_lo <= i_box.s_hi && r_box.s_hi >= i_box.s_lo
                && r_box.p_lo <= i_box.p_hi && r_box.p_hi >= i_box.p_lo
                && r_box.o_lo <= i_box.o_hi && r_box.o_hi >= i_box.o_lo;
    assign o_valid     = r_valid;
    assign o_owner     = r_owner;
    // conflicts unless owner committed (checked by sequencer)
    assign o_candidate = r_valid && w_ovl && r_owner != i_txn && (i_excl || r_excl);
endmodule
`default_nettype wire

// ===== sv/range_lock_table_top.sv =====
// Top level: lock table cells, ID set cells and the scanning sequencer.
// A request scans the lock cells in turn, checking each lock candidate's owner against
// the committed set, one per cycle; a finish walks the active cells to find the oldest.
// One item at a time: the next beat is taken in the cycle after the result is loaded;
// a held result only stalls the final load.
// Synchronous active-low reset clears all valid bits, the sequencer and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module range_lock_table_top #(
    parameter int LOCK_SLOTS      = 16,
    parameter int ACTIVE_SLOTS    = 16,
    parameter int COMMITTED_SLOTS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // transaction[31:0], s_lo,s_hi,p_lo,p_hi,o_lo,o_hi [223:32], exclusive[224]
    input  wire  [231:0] s_axis_tdata,
    // action[0]
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // granted[0], status[3:1], released_oldest[4]
    output logic [7:0]   m_axis_tdata
);
    localparam int LW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
    localparam int CW = $clog2(LOCK_SLOTS + ACTIVE_SLOTS + 2);
    localparam logic [1:0] S_IDLE = 2'd0, S_REQ = 2'd1, S_FIN = 2'd2, S_DONE = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_txn;
    rlt_pkg::t_box r_box;
    logic          r_excl;
    logic          r_conf;
    logic          r_any;
    logic [31:0]   r_old;
    logic          r_ovalid;
    logic          r_gr, r_rel;
    logic [2:0]    r_st;
    // finished result waiting for the output register
    logic          r_pgr, r_prel;
    logic [2:0]    r_pst;

    logic [LOCK_SLOTS-1:0]      w_lv, w_cand, w_lwr;
    logic [31:0]                w_lown [LOCK_SLOTS];
    logic [ACTIVE_SLOTS-1:0]    w_av, w_ahit, w_awr;
    logic [31:0]                w_aid [ACTIVE_SLOTS];
    logic [COMMITTED_SLOTS-1:0] w_cv, w_chit, w_cwr;
    logic [31:0]                w_cid [COMMITTED_SLOTS];
    logic [COMMITTED_SLOTS-1:0] w_khit;
    logic [31:0]                w_cown [COMMITTED_SLOTS];
    logic w_purge, w_aclr;
    logic w_req_end, w_fin_end;
    logic w_out_free, w_load;

    // committed check for candidate owner at scan index
    logic [31:0] w_scan_owner;
    logic        w_scan_cand;
    logic        w_owner_comm;
    assign w_scan_owner = w_lown[r_cnt[LW-1:0]];
    assign w_scan_cand  = w_cand[r_cnt[LW-1:0]];

    genvar g;
    generate
        for (g = 0; g < LOCK_SLOTS; g++) begin : g_lock
            rlt_lock_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_lwr[g]), .i_purge(w_purge),
                .i_txn(r_txn), .i_box(r_box), .i_excl(r_excl),
                .o_valid(w_lv[g]), .o_owner(w_lown[g]), .o_candidate(w_cand[g]));
        end
        for (g = 0; g < ACTIVE_SLOTS; g++) begin : g_act
            rlt_id_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_awr[g]), .i_wr_id(r_txn),
                .i_clr_eq(w_aclr), .i_clr_le(1'b0), .i_key(r_txn),
                .o_valid(w_av[g]), .o_id(w_aid[g]), .o_hit(w_ahit[g]));
        end
        for (g = 0; g < COMMITTED_SLOTS; g++) begin : g_com
            rlt_id_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_cwr[g]), .i_wr_id(r_txn),
                .i_clr_eq(1'b0), .i_clr_le(w_purge), .i_key(r_txn),
                .o_valid(w_cv[g]), .o_id(w_cid[g]), .o_hit(w_chit[g]));
            assign w_cown[g] = w_cid[g];
            assign w_khit[g] = w_cv[g] && w_cown[g] == w_scan_owner;
        end
    endgenerate
    assign w_owner_comm = |w_khit;

    // lowest-free pickers
    function automatic logic [LOCK_SLOTS-1:0] f_first_l(input logic [LOCK_SLOTS-1:0] v);
        logic [LOCK_SLOTS-1:0] r;
        logic f;
        r = '0; f = 1'b0;
        for (int k = 0; k < LOCK_SLOTS; k++) if (!v[k] && !f) begin r[k] = 1'b1; f = 1'b1; end
        return r;
    endfunction
    function automatic logic [ACTIVE_SLOTS-1:0] f_first_a(input logic [ACTIVE_SLOTS-1:0] v);
        logic [ACTIVE_SLOTS-1:0] r;
        logic f;
        r = '0; f = 1'b0;
        for (int k = 0; k < ACTIVE_SLOTS; k++) if (!v[k] && !f) begin r[k] = 1'b1; f = 1'b1; end
        return r;
    endfunction
    function automatic logic [COMMITTED_SLOTS-1:0] f_first_c(
        input logic [COMMITTED_SLOTS-1:0] v);
        logic [COMMITTED_SLOTS-1:0] r;
        logic f;
        r = '0; f = 1'b0;
        for (int k = 0; k < COMMITTED_SLOTS; k++) if (!v[k] && !f) begin r[k] = 1'b1; f = 1'b1; end
        return r;
    endfunction

    logic w_lfull, w_afull, w_cfull, w_isact, w_iscom, w_oldest;
    assign w_lfull  = &w_lv;
    assign w_afull  = &w_av;
    assign w_cfull  = &w_cv;
    assign w_isact  = |w_ahit;
    assign w_iscom  = |w_chit;
    assign w_req_end = r_state == S_REQ && r_cnt == CW'(LOCK_SLOTS - 1);
    assign w_fin_end = r_state == S_FIN && r_cnt == CW'(ACTIVE_SLOTS);
    assign w_oldest  = r_any && r_old == r_txn;

    logic w_conf_now, w_grant;
    assign w_conf_now = r_conf || (w_scan_cand && !w_owner_comm);
    assign w_grant = w_req_end && !w_conf_now && !w_lfull && (w_isact || !w_afull);
    assign w_lwr   = w_grant ? f_first_l(w_lv) : '0;
    assign w_awr   = (w_grant && !w_isact) ? f_first_a(w_av) : '0;
    assign w_purge = w_fin_end && w_oldest;
    assign w_aclr  = w_purge;
    assign w_cwr   = (w_fin_end && !w_oldest && !w_iscom && !w_cfull) ? f_first_c(w_cv) : '0;

    // output register free this cycle: empty, or its beat leaves now
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_load     = r_state == S_DONE && w_out_free;

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b0, r_rel, r_st, r_gr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_txn  <= s_axis_tdata[31:0];
                    r_box  <= s_axis_tdata[223:32];
                    r_excl <= s_axis_tdata[224];
                    r_cnt  <= '0;
                    r_conf <= 1'b0;
                    r_any  <= 1'b0;
                    r_state <= (s_axis_tuser[0] == rlt_pkg::ACT_FINISH) ? S_FIN : S_REQ;
                end
                S_REQ: begin
                    r_conf <= w_conf_now;
                    r_cnt  <= r_cnt + 1'b1;
                    if (w_req_end) begin
                        r_pgr  <= w_grant;
                        r_prel <= 1'b0;
                        r_pst  <= w_conf_now ? rlt_pkg::ST_CONFLICT :
                                  w_lfull ? rlt_pkg::ST_LOCK_FULL :
                                  (!w_isact && w_afull) ? rlt_pkg::ST_ACTIVE_FULL :
                                  rlt_pkg::ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_FIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!w_fin_end) begin
                        if (w_av[r_cnt[AW-1:0]] &&
                            (!r_any || w_aid[r_cnt[AW-1:0]] < r_old)) begin
                            r_any <= 1'b1;
                            r_old <= w_aid[r_cnt[AW-1:0]];
                        end
                    end else begin
                        r_pgr  <= 1'b0;
                        r_prel <= w_oldest;
                        r_pst  <= (!w_oldest && !w_iscom && w_cfull) ?
                                  rlt_pkg::ST_COMMITTED_FULL : rlt_pkg::ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: if (w_out_free) begin
                    r_gr    <= r_pgr;
                    r_st    <= r_pst;
                    r_rel   <= r_prel;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/rlt_checker.sv =====
// Port-level checker for the range lock table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rlt_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [7:0]   m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[3:1] == rlt_pkg::ST_OK && !m_axis_tdata[4])
        else $error("grant with bad status");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:1] <= rlt_pkg::ST_COMMITTED_FULL)
        else $error("status out of range");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule
bind range_lock_table_top rlt_checker u_rlt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

// ===== sim/tb_range_lock_table_top.sv =====
// Self-checking testbench for range_lock_table_top: directed and random lock traffic.
`timescale 1ns / 1ps
module tb_range_lock_table_top;

    localparam int NSLOT      = 16;
    localparam int IDLE_LIMIT = 3000;   // cycles with no beat on either side
    localparam int HOLD_LEN   = 400;    // long receiver back-off

    typedef struct {
        logic        action;
        logic [31:0] txn;
        logic [31:0] bnd [6];   // s_lo, s_hi, p_lo, p_hi, o_lo, o_hi
        logic        excl;
    } t_lock_op;

    typedef struct {
        logic       granted;
        logic [2:0] status;
        logic       released;
    } t_lock_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    range_lock_table_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the table
    logic        sh_lock_v   [NSLOT];
    logic [31:0] sh_lock_own [NSLOT];
    logic        sh_lock_x   [NSLOT];
    logic [31:0] sh_lock_b   [NSLOT][6];
    logic        sh_act_v    [NSLOT];
    logic [31:0] sh_act_id   [NSLOT];
    logic        sh_com_v    [NSLOT];
    logic [31:0] sh_com_id   [NSLOT];

    t_lock_op  op_q  [$];
    t_lock_res res_q [$];

    int src_idle = 0;
    int snk_idle = 0;
    int n_err    = 0;
    int acc_cnt  = 0;
    int drv_seen = 0;
    int idle_cyc = 0;
    int hold_left = 0;
    bit hold_req = 0;
    bit hold_ack = 0;

    function automatic logic [231:0] pack_op(t_lock_op op);
        logic [231:0] d;
        d = '0;
        d[31:0] = op.txn;
        for (int k = 0; k < 6; k++) d[32 + 32*k +: 32] = op.bnd[k];
        d[224]  = op.excl;
        return d;
    endfunction

    function automatic t_lock_op unpack_op(logic [0:0] u, logic [231:0] d);
        t_lock_op op;
        op.action = u[0];
        op.txn    = d[31:0];
        for (int k = 0; k < 6; k++) op.bnd[k] = d[32 + 32*k +: 32];
        op.excl   = d[224];
        return op;
    endfunction

    function automatic void enqueue_op(t_lock_op op);
        op_q.insert(op_q.size(), op);
    endfunction

    function automatic bit id_committed(logic [31:0] t);
        for (int i = 0; i < NSLOT; i++)
            if (sh_com_v[i] && sh_com_id[i] == t) return 1;
        return 0;
    endfunction

    // Apply one op to the shadow table and return the expected outcome.
    function automatic t_lock_res apply_lock_op(t_lock_op op);
        t_lock_res r;
        int lslot, aslot, cslot;
        bit ovl, is_act, any;
        logic [31:0] oldest;
        r = '{granted: 1'b0, status: rlt_pkg::ST_OK, released: 1'b0};
        lslot = -1; aslot = -1; cslot = -1; is_act = 0; any = 0; oldest = '0;
        if (op.action == rlt_pkg::ACT_REQUEST) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!sh_lock_v[i]) continue;
                ovl = 1;
                for (int a = 0; a < 3; a++)
                    if (!(sh_lock_b[i][2*a] <= op.bnd[2*a+1] &&
                          sh_lock_b[i][2*a+1] >= op.bnd[2*a])) ovl = 0;
                if (!ovl || sh_lock_own[i] == op.txn) continue;
                if (!op.excl && !sh_lock_x[i]) continue;
                if (id_committed(sh_lock_own[i])) continue;
                r.status = rlt_pkg::ST_CONFLICT;
                return r;
            end
            for (int i = NSLOT - 1; i >= 0; i--) if (!sh_lock_v[i]) lslot = i;
            if (lslot < 0) begin
                r.status = rlt_pkg::ST_LOCK_FULL;
                return r;
            end
            for (int i = 0; i < NSLOT; i++)
                if (sh_act_v[i] && sh_act_id[i] == op.txn) is_act = 1;
            if (!is_act) begin
                for (int i = NSLOT - 1; i >= 0; i--) if (!sh_act_v[i]) aslot = i;
                if (aslot < 0) begin
                    r.status = rlt_pkg::ST_ACTIVE_FULL;
                    return r;
                end
                sh_act_v[aslot]  = 1;
                sh_act_id[aslot] = op.txn;
            end
            sh_lock_v[lslot]   = 1;
            sh_lock_own[lslot] = op.txn;
            sh_lock_x[lslot]   = op.excl;
            for (int k = 0; k < 6; k++) sh_lock_b[lslot][k] = op.bnd[k];
            r.granted = 1;
            return r;
        end
        for (int i = 0; i < NSLOT; i++)
            if (sh_act_v[i] && (!any || sh_act_id[i] < oldest)) begin
                oldest = sh_act_id[i];
                any = 1;
            end
        if (any && op.txn == oldest) begin
            // oldest finishes: purge everything at or below it
            for (int i = 0; i < NSLOT; i++) begin
                if (sh_act_v[i] && sh_act_id[i] == op.txn) sh_act_v[i] = 0;
                if (sh_com_v[i] && sh_com_id[i] <= op.txn) sh_com_v[i] = 0;
                if (sh_lock_v[i] && sh_lock_own[i] <= op.txn) sh_lock_v[i] = 0;
            end
            r.released = 1;
            return r;
        end
        if (id_committed(op.txn)) return r;
        for (int i = NSLOT - 1; i >= 0; i--) if (!sh_com_v[i]) cslot = i;
        if (cslot < 0) begin
            r.status = rlt_pkg::ST_COMMITTED_FULL;
            return r;
        end
        sh_com_v[cslot]  = 1;
        sh_com_id[cslot] = op.txn;
        return r;
    endfunction

    function automatic t_lock_op mk_op(logic act, logic [31:0] t,
                                       logic [31:0] lo, logic [31:0] hi, logic x);
        t_lock_op op;
        op.action = act;
        op.txn    = t;
        for (int a = 0; a < 3; a++) begin
            op.bnd[2*a]   = lo;
            op.bnd[2*a+1] = hi;
        end
        op.excl = x;
        return op;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(19))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(15);
        endcase
    endfunction

    function automatic t_lock_op rand_op(int pool);
        t_lock_op op;
        logic [31:0] tmp;
        op.action = ($urandom_range(99) < 30) ? rlt_pkg::ACT_FINISH : rlt_pkg::ACT_REQUEST;
        case ($urandom_range(39))
            0:       op.txn = 32'h0;
            1:       op.txn = 32'hFFFF_FFFF;
            2:       op.txn = $urandom;
            default: op.txn = $urandom_range(pool, 1);
        endcase
        for (int a = 0; a < 3; a++) begin
            op.bnd[2*a]   = rand_coord();
            op.bnd[2*a+1] = rand_coord();
            // mostly well-ordered boxes, a few inverted ones
            if (op.bnd[2*a] > op.bnd[2*a+1] && $urandom_range(9) != 0) begin
                tmp = op.bnd[2*a];
                op.bnd[2*a] = op.bnd[2*a+1];
                op.bnd[2*a+1] = tmp;
            end
        end
        op.excl = $urandom_range(1);
        return op;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: new beat offered at the falling edge
    always @(negedge i_clk) begin
        t_lock_op op;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else if (!s_axis_tvalid || acc_cnt != drv_seen) begin
            drv_seen <= acc_cnt;
            if (op_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                op = op_q.pop_front();
                s_axis_tdata  <= pack_op(op);
                s_axis_tuser  <= op.action;
                s_axis_tvalid <= 1;
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // result-side ready, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge i_clk) begin
        t_lock_res ex;
        bit beat;
        beat = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                sh_lock_v[i] = 0;
                sh_act_v[i]  = 0;
                sh_com_v[i]  = 0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                res_q.insert(res_q.size(),
                             apply_lock_op(unpack_op(s_axis_tuser, s_axis_tdata)));
                acc_cnt <= acc_cnt + 1;
                beat = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                beat = 1;
                if (res_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                    n_err = n_err + 1;
                end else begin
                    ex = res_q.pop_front();
                    if (m_axis_tdata[0] !== ex.granted) begin
                        $error("granted: exp %0d got %0d", ex.granted, m_axis_tdata[0]);
                        n_err = n_err + 1;
                    end
                    if (m_axis_tdata[3:1] !== ex.status) begin
                        $error("status: exp %0d got %0d", ex.status, m_axis_tdata[3:1]);
                        n_err = n_err + 1;
                    end
                    if (m_axis_tdata[4] !== ex.released) begin
                        $error("released_oldest: exp %0d got %0d",
                               ex.released, m_axis_tdata[4]);
                        n_err = n_err + 1;
                    end
                end
            end
            idle_cyc <= beat ? 0 : idle_cyc + 1;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("tb_range_lock_table_top: FAIL");
                $finish;
            end
        end
    end

    task automatic drain();
        while (op_q.size() != 0 || s_axis_tvalid || res_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // directed
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd9, 0, 0, 0));              // none active
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd9, 0, 0, 0));              // already committed
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd5, 0, 32'hFFFF_FFFF, 1)); // whole space
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd6, 3, 4, 0));             // conflict
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd5, 3, 4, 1));             // own lock
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd5, 0, 0, 0));              // oldest, purge
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd6, 2, 8, 0));
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd7, 3, 4, 0));             // shared+shared
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd8, 3, 3, 1));             // conflict
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd7, 0, 0, 0));              // commit, not oldest
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd8, 9, 8, 1));             // inverted box
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 1));
        enqueue_op(mk_op(rlt_pkg::ACT_REQUEST, 32'd0, 0, 0, 1));
        // fill the committed set while txn 0 stays oldest
        for (int k = 0; k < 14; k++)
            enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd100 + k, 0, 0, 0));
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd200, 0, 0, 0));           // committed full
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'd0, 0, 0, 0));
        enqueue_op(mk_op(rlt_pkg::ACT_FINISH, 32'hFFFF_FFFF, 0, 0, 0));
        drain();    // sender pause until every result is back

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle = 0;  snk_idle = 0;  end
                1: begin src_idle = 48; snk_idle = 0;  end
                2: begin src_idle = 0;  snk_idle = 48; end
                default: begin src_idle = 38; snk_idle = 38; end
            endcase
            for (int n = 0; n < 130; n++)
                enqueue_op(rand_op((ph % 2) ? 40 : 8));
            if (ph == 0) begin
                repeat (20) @(posedge i_clk);
                hold_req = ~hold_req;
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (n_err == 0 && res_q.size() == 0) begin
            $display("tb_range_lock_table_top: PASS");
        end else begin
            $display("tb_range_lock_table_top: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/rlt_pkg.sv
sv/rlt_id_cell.sv
sv/rlt_lock_cell.sv
sv/range_lock_table_top.sv
sv/rlt_checker.sv
sim/tb_range_lock_table_top.sv
